// File: hw/rtl/rag_pkg.sv
// rag_pkg: shared constants and types for the rational accumulator.
// No dependencies; imported by the rational_accumulator_gcd_reduce top level.
`timescale 1ns / 1ps

package rag_pkg;

  // default internal word width of the fraction parts
  parameter int WORD_WIDTH_DEF = 32;

  // width of the fixed item and result fields
  parameter int FIELD_WIDTH = 32;

  // action codes carried by an input word
  typedef enum logic [2:0] {
    ACT_LOAD = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } action_t;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_GCD  = 7'b0000100,
    ST_REM  = 7'b0001000,
    ST_QNUM = 7'b0010000,
    ST_QDEN = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/rational_accumulator_gcd_reduce.sv
// rational_accumulator_gcd_reduce: fraction accumulator with Euclid GCD reduction.
// Depends on rag_pkg (action codes, state type, default word width).
`timescale 1ns / 1ps

// The block holds a signed fraction numerator/denominator of WORD_WIDTH bits
// (reset 0/1) and takes one input word at a time: load, add, subtract, multiply
// or divide by an integer operand (other codes only reduce), followed by
// reduction by the signed Euclid GCD, with one result word per input word. All
// arithmetic is digit serial over one shared shift-add multiplier and one
// shared restoring divider, each retiring one bit per cycle. Add, subtract,
// multiply and divide first run the multiplier; load and the other codes go
// straight to the Euclid loop, whose number of remainder steps is data
// dependent (at most about 1.44*W, where W is WORD_WIDTH). When both parts are
// zero the quotient passes are skipped. item_stall is high from acceptance
// until the result has been placed in the output register; a finished result
// may wait there while the next input word is taken.
module rational_accumulator_gcd_reduce #(
  parameter int WORD_WIDTH = rag_pkg::WORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [2:0]                           action,
  input  logic signed [rag_pkg::FIELD_WIDTH-1:0] operand,
  input  logic signed [rag_pkg::FIELD_WIDTH-1:0] load_denominator,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [rag_pkg::FIELD_WIDTH-1:0] numerator_out,
  output logic signed [rag_pkg::FIELD_WIDTH-1:0] denominator_out,
  output logic signed [rag_pkg::FIELD_WIDTH-1:0] gcd_used,
  output logic                                 zero_gcd_flag
);

  import rag_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  state_t state;

  // architectural fraction
  logic [W-1:0] num;
  logic [W-1:0] den;

  // Euclid pair, ga ends up holding the GCD
  logic [W-1:0] ga;
  logic [W-1:0] gb;
  logic         zero;

  // serial multiplier
  logic [W-1:0] acc;
  logic [W-1:0] mcand;
  logic [W-1:0] mplier;
  logic         tgt_den;

  // serial divider
  logic [W-1:0] dvd;
  logic [W-1:0] dsr;
  logic [W-1:0] rem;
  logic         qneg;
  logic         rneg;

  logic [CW-1:0] cnt;

  // combinational helpers
  logic [W-1:0] op_w;
  logic [W-1:0] ld_w;
  logic [W-1:0] acc_step;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  logic         rem_ge;
  logic [W-1:0] rem_step;
  logic [W-1:0] dvd_step;
  logic [W-1:0] quot_signed;
  logic [W-1:0] rem_signed;
  logic [W-1:0] dv_x;
  logic [W-1:0] dv_y;
  logic [W-1:0] dv_x_mag;
  logic [W-1:0] dv_y_mag;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? ('0 - v) : v;
  endfunction

  // accept a new word only while idle
  assign item_stall = (state != ST_IDLE);

  // wrap the 32-bit fields to the word width
  assign op_w = W'(operand);
  assign ld_w = W'(load_denominator);

  // one shift-add multiplier step
  assign acc_step = acc + (mplier[0] ? mcand : '0);

  // one restoring division step
  always_comb begin
    rem_sh      = {rem, dvd[W-1]};
    rem_sub     = rem_sh - {1'b0, dsr};
    rem_ge      = !rem_sub[W];
    rem_step    = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
    dvd_step    = {dvd[W-2:0], rem_ge};
    quot_signed = qneg ? ('0 - dvd_step) : dvd_step;
    rem_signed  = rneg ? ('0 - rem_step) : rem_step;
  end

  // pick the operands of the next division
  always_comb begin
    case (state)
      ST_GCD: begin
        dv_x = (gb != '0) ? ga : num;
        dv_y = (gb != '0) ? gb : ga;
      end
      ST_QNUM: begin
        dv_x = den;
        dv_y = ga;
      end
      default: begin
        dv_x = num;
        dv_y = ga;
      end
    endcase
    dv_x_mag = mag(dv_x);
    dv_y_mag = mag(dv_y);
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      num          <= '0;
      den          <= W'(1);
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (result_valid && !result_stall && state != ST_FIN) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            tgt_den <= (action == ACT_DIV);
            mplier  <= op_w;
            cnt     <= CNT_LAST;
            case (action)
              ACT_LOAD: begin
                num   <= op_w;
                den   <= ld_w;
                ga    <= op_w;
                gb    <= ld_w;
                state <= ST_GCD;
              end
              ACT_ADD: begin
                acc   <= num;
                mcand <= den;
                state <= ST_MUL;
              end
              ACT_SUB: begin
                acc   <= num;
                mcand <= '0 - den;
                state <= ST_MUL;
              end
              ACT_MUL: begin
                acc   <= '0;
                mcand <= num;
                state <= ST_MUL;
              end
              ACT_DIV: begin
                acc   <= '0;
                mcand <= den;
                state <= ST_MUL;
              end
              default: begin
                ga    <= num;
                gb    <= den;
                state <= ST_GCD;
              end
            endcase
          end
        end

        // advance the multiplier one operand bit
        ST_MUL: begin
          acc    <= acc_step;
          mcand  <= {mcand[W-2:0], 1'b0};
          mplier <= {1'b0, mplier[W-1:1]};
          cnt    <= cnt - CW'(1);
          if (cnt == '0) begin
            if (tgt_den) begin
              den <= acc_step;
              ga  <= num;
              gb  <= acc_step;
            end else begin
              num <= acc_step;
              ga  <= acc_step;
              gb  <= den;
            end
            state <= ST_GCD;
          end
        end

        // test the Euclid pair: start a remainder, the first quotient or the finish
        ST_GCD: begin
          dvd  <= dv_x_mag;
          dsr  <= dv_y_mag;
          rem  <= '0;
          qneg <= dv_x[W-1] ^ dv_y[W-1];
          rneg <= dv_x[W-1];
          cnt  <= CNT_LAST;
          if (gb != '0) begin
            state <= ST_REM;
          end else if (ga == '0) begin
            zero  <= 1'b1;
            state <= ST_FIN;
          end else begin
            zero  <= 1'b0;
            state <= ST_QNUM;
          end
        end

        // serial remainder, then shift the pair
        ST_REM: begin
          dvd <= dvd_step;
          rem <= rem_step;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            ga    <= gb;
            gb    <= rem_signed;
            state <= ST_GCD;
          end
        end

        // numerator quotient, then start the denominator
        ST_QNUM: begin
          if (cnt == '0) begin
            num   <= quot_signed;
            dvd   <= dv_x_mag;
            dsr   <= dv_y_mag;
            rem   <= '0;
            qneg  <= dv_x[W-1] ^ dv_y[W-1];
            rneg  <= dv_x[W-1];
            cnt   <= CNT_LAST;
            state <= ST_QDEN;
          end else begin
            dvd <= dvd_step;
            rem <= rem_step;
            cnt <= cnt - CW'(1);
          end
        end

        // denominator quotient
        ST_QDEN: begin
          dvd <= dvd_step;
          rem <= rem_step;
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            den   <= quot_signed;
            state <= ST_FIN;
          end
        end

        // hold until the output register is free
        ST_FIN: begin
          if (!result_valid || !result_stall) begin
            numerator_out   <= FIELD_WIDTH'(signed'(num));
            denominator_out <= FIELD_WIDTH'(signed'(den));
            gcd_used        <= FIELD_WIDTH'(signed'(ga));
            zero_gcd_flag   <= zero;
            result_valid    <= 1'b1;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rag_checker.sv
// rag_checker: port-level assertions for rational_accumulator_gcd_reduce.
// Depends only on the top level's ports; attached by the bind at the end.
`timescale 1ns / 1ps

module rag_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic [2:0]         action,
  input logic signed [31:0] operand,
  input logic signed [31:0] load_denominator,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] numerator_out,
  input logic signed [31:0] denominator_out,
  input logic signed [31:0] gcd_used,
  input logic               zero_gcd_flag
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(numerator_out)
      && $stable(denominator_out) && $stable(gcd_used) && $stable(zero_gcd_flag))
    else $error("stalled result word changed");

  // one word at a time: an accepted word closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input open right after accepting a word");

  // skipped reduction reports an all-zero fraction
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_gcd_flag |->
      numerator_out == 32'sd0 && denominator_out == 32'sd0 && gcd_used == 32'sd0)
    else $error("zero flag with nonzero fields");

  // an applied divisor is never zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !zero_gcd_flag |-> gcd_used != 32'sd0)
    else $error("zero divisor reported without flag");

endmodule

bind rational_accumulator_gcd_reduce rag_checker u_rag_checker (.*);

// File: sim/tb_top.sv
// tb_top: self-checking testbench for rational_accumulator_gcd_reduce.
// Depends on rag_pkg and the rational_accumulator_gcd_reduce RTL; predicts each
// reduced fraction in SystemVerilog and checks every result word against it.
`timescale 1ns / 1ps

module tb_top;
  import rag_pkg::*;

  typedef logic [FIELD_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t num;
    word_t den;
    word_t gcd;
    logic  zero;
  } fraction_t;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t WORD_ONE = 32'h0000_0001;
  localparam word_t WORD_NEG_ONE = 32'hFFFF_FFFF;

  // action codes with no operation behind them
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // cycle limit sized for ~1100 items with long gaps
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int SETTLE_CYCLES = 2000;

  logic  clk = 1'b0;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  logic  [2:0] action;
  word_t operand;
  word_t load_denominator;
  logic  result_valid;
  logic  result_stall;
  word_t numerator_out;
  word_t denominator_out;
  word_t gcd_used;
  logic  zero_gcd_flag;

  // predicted fraction state, mirrors the block
  word_t acc_num = '0;
  word_t acc_den = WORD_ONE;

  fraction_t pending_fractions[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  rational_accumulator_gcd_reduce uut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .action           (action),
    .operand          (operand),
    .load_denominator (load_denominator),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .numerator_out    (numerator_out),
    .denominator_out  (denominator_out),
    .gcd_used         (gcd_used),
    .zero_gcd_flag    (zero_gcd_flag)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic word_t magnitude(input word_t v);
    return v[FIELD_WIDTH-1] ? word_t'(-v) : v;
  endfunction

  // remainder truncated toward zero, sign follows the dividend
  function automatic word_t trunc_rem(input word_t a, input word_t b);
    word_t r;
    r = magnitude(a) % magnitude(b);
    return a[FIELD_WIDTH-1] ? word_t'(-r) : r;
  endfunction

  // quotient truncated toward zero; MIN / -1 wraps to MIN
  function automatic word_t trunc_quot(input word_t a, input word_t b);
    word_t q;
    q = magnitude(a) / magnitude(b);
    return (a[FIELD_WIDTH-1] ^ b[FIELD_WIDTH-1]) ? word_t'(-q) : q;
  endfunction

  // apply one word to the fraction, reduce by the signed Euclid divisor
  function automatic fraction_t reduce_fraction(input logic [2:0] act, input word_t opd,
                                                input word_t lden);
    fraction_t res;
    word_t a;
    word_t b;
    word_t t;
    case (act)
      ACT_LOAD: begin
        acc_num = opd;
        acc_den = lden;
      end
      ACT_ADD: acc_num = acc_num + opd * acc_den;
      ACT_SUB: acc_num = acc_num - opd * acc_den;
      ACT_MUL: acc_num = acc_num * opd;
      ACT_DIV: acc_den = acc_den * opd;
      default: ;
    endcase
    a = acc_num;
    b = acc_den;
    while (b != '0) begin
      t = trunc_rem(a, b);
      a = b;
      b = t;
    end
    res.zero = (a == '0);
    if (!res.zero) begin
      acc_num = trunc_quot(acc_num, a);
      acc_den = trunc_quot(acc_den, a);
    end
    res.num = acc_num;
    res.den = acc_den;
    res.gcd = a;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return word_t'($urandom_range(0, 40)) - word_t'(20);
    if (r < 55) return $urandom;
    if (r < 70) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return WORD_ONE;
        2: return WORD_NEG_ONE;
        3: return WORD_MAX;
        default: return WORD_MIN;
      endcase
    end
    if (r < 85) return {{16{1'b0}}, 16'($urandom)} - word_t'(32768);
    return $urandom_range(0, 1) ? (WORD_ONE << $urandom_range(0, 31))
                                : word_t'(-(WORD_ONE << $urandom_range(0, 31)));
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return ACT_LOAD;
    if (r < 95) begin
      case ($urandom_range(0, 3))
        0: return ACT_ADD;
        1: return ACT_SUB;
        2: return ACT_MUL;
        default: return ACT_DIV;
      endcase
    end
    return 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // offer one word, hold it until taken, then record its prediction
  task automatic send_word(input logic [2:0] act, input word_t opd, input word_t lden);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid       <= 1'b1;
    action           <= act;
    operand          <= opd;
    load_denominator <= lden;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_fractions.push_back(reduce_fraction(act, opd, lden));
  endtask

  // drop valid and hold until every predicted result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_fractions.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // random stall on the result channel
  initial begin
    int hold;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = quiet ? 0 : pick_gap();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic check_part(input string label, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    fraction_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_fractions.size() == 0) begin
        $display("%0t: result word with none expected, actual %h/%h gcd %h zero %b",
                 $time, numerator_out, denominator_out, gcd_used, zero_gcd_flag);
        mismatch_count++;
      end else begin
        want = pending_fractions.pop_front();
        check_part("numerator_out", want.num, numerator_out);
        check_part("denominator_out", want.den, denominator_out);
        check_part("gcd_used", want.gcd, gcd_used);
        check_part("zero_gcd_flag", word_t'(want.zero), word_t'(zero_gcd_flag));
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // corner fractions, every action, spare codes, sign moves, wraps
  task automatic test_directed_corners();
    send_word(ACT_SPARE_LO, '0, '0);            // reset state 0/1 reduced again
    send_word(ACT_LOAD, '0, '0);                // both parts zero
    send_word(ACT_SPARE_MID, WORD_MAX, WORD_MIN);
    send_word(ACT_ADD, 32'd7, '0);
    send_word(ACT_LOAD, 32'd5, '0);             // zero denominator, positive
    send_word(ACT_LOAD, word_t'(-7), '0);       // zero denominator, negative
    send_word(ACT_LOAD, '0, word_t'(-3));
    send_word(ACT_LOAD, WORD_MIN, WORD_NEG_ONE); // quotient overflow
    send_word(ACT_LOAD, WORD_MAX, WORD_MIN);
    send_word(ACT_MUL, WORD_NEG_ONE, '0);
    send_word(ACT_DIV, WORD_MIN, '0);
    send_word(ACT_ADD, WORD_MAX, WORD_MAX);
    send_word(ACT_SUB, WORD_MIN, WORD_MIN);
    send_word(ACT_LOAD, 32'd12, word_t'(-18));  // sign moves to numerator
    send_word(ACT_DIV, '0, '0);
    send_word(ACT_MUL, '0, '0);
    send_word(ACT_SPARE_HI, WORD_NEG_ONE, WORD_NEG_ONE);
    send_word(ACT_LOAD, WORD_NEG_ONE, WORD_NEG_ONE);
    send_word(ACT_LOAD, WORD_MIN, WORD_MIN);
    send_word(ACT_LOAD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(ACT_LOAD, 32'd6, 32'd4);
    send_word(ACT_ADD, 32'd1, '0);
    send_word(ACT_SUB, word_t'(-3), '0);
    send_word(ACT_MUL, 32'd2, '0);
    send_word(ACT_DIV, word_t'(-5), '0);
  endtask

  // load a fraction, then run a chain of operations on it
  task automatic test_random_traffic(input int count);
    int sent;
    int run_len;
    sent = 0;
    while (sent < count) begin
      send_word(ACT_LOAD, pick_value(), pick_value());
      sent++;
      run_len = $urandom_range(1, 10);
      repeat (run_len) begin
        send_word(pick_action(), pick_value(), pick_value());
        sent++;
      end
    end
  endtask

  // no gaps and no stalls
  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    test_random_traffic(count);
    quiet = 1'b0;
  endtask

  // wait for an empty pipeline before each word
  task automatic test_drain_pause(input int count);
    repeat (count) begin
      drain_results();
      send_word(pick_action(), pick_value(), pick_value());
    end
  endtask

  initial begin
    rst              <= 1'b1;
    item_valid       <= 1'b0;
    action           <= ACT_LOAD;
    operand          <= '0;
    load_denominator <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_traffic(780);
    test_back_to_back(200);
    test_drain_pause(40);

    // let the last results come back
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_fractions.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
